@@ rtl/morse_symbol_decoder_top_macros.svh @@
// Assertion macros used by the RTL.
`ifndef MORSE_SYMBOL_DECODER_TOP_MACROS_SVH
`define MORSE_SYMBOL_DECODER_TOP_MACROS_SVH

// Same-cycle implication, checked on every clock outside reset.
`define MSD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock outside reset.
`define MSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/msd_pkg.sv @@
package msd_pkg;

  localparam int unsigned LEN_W = 4;
  localparam int unsigned PATTERN_BITS = 8;
  localparam logic [LEN_W-1:0] MAX_CODE_LENGTH = 4'd8;

  localparam logic [7:0] SEPARATOR_RESET = 8'h20;
  localparam logic [7:0] CHAR_DOT = 8'h2E;
  localparam logic [7:0] CHAR_DASH = 8'h2D;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_NONE = 8'h00;

  typedef struct packed {
    logic [7:0] symbol;
    logic       end_of_message;
  } sym_in_t;

  typedef struct packed {
    logic [7:0] character;
    logic       char_valid;
    logic       decode_error;
    logic       last;
  } sym_out_t;

  // Element i sits in bit i, dash = 1. Returns CHAR_NONE when no entry matches.
  function automatic logic [7:0] morse_lookup(input logic [LEN_W-1:0] len,
                                              input logic [PATTERN_BITS-1:0] pat);
    logic [7:0] ch;
    unique case ({len, pat})
      {4'd2, 8'b00000010}: ch = "A";
      {4'd4, 8'b00000001}: ch = "B";
      {4'd4, 8'b00000101}: ch = "C";
      {4'd3, 8'b00000001}: ch = "D";
      {4'd1, 8'b00000000}: ch = "E";
      {4'd4, 8'b00000100}: ch = "F";
      {4'd3, 8'b00000011}: ch = "G";
      {4'd4, 8'b00000000}: ch = "H";
      {4'd2, 8'b00000000}: ch = "I";
      {4'd4, 8'b00001110}: ch = "J";
      {4'd3, 8'b00000101}: ch = "K";
      {4'd4, 8'b00000010}: ch = "L";
      {4'd2, 8'b00000011}: ch = "M";
      {4'd2, 8'b00000001}: ch = "N";
      {4'd3, 8'b00000111}: ch = "O";
      {4'd4, 8'b00000110}: ch = "P";
      {4'd4, 8'b00001011}: ch = "Q";
      {4'd3, 8'b00000010}: ch = "R";
      {4'd3, 8'b00000000}: ch = "S";
      {4'd1, 8'b00000001}: ch = "T";
      {4'd3, 8'b00000100}: ch = "U";
      {4'd4, 8'b00001000}: ch = "V";
      {4'd3, 8'b00000110}: ch = "W";
      {4'd4, 8'b00001001}: ch = "X";
      {4'd4, 8'b00001101}: ch = "Y";
      {4'd4, 8'b00000011}: ch = "Z";
      {4'd5, 8'b00011111}: ch = "0";
      {4'd5, 8'b00011110}: ch = "1";
      {4'd5, 8'b00011100}: ch = "2";
      {4'd5, 8'b00011000}: ch = "3";
      {4'd5, 8'b00010000}: ch = "4";
      {4'd5, 8'b00000000}: ch = "5";
      {4'd5, 8'b00000001}: ch = "6";
      {4'd5, 8'b00000011}: ch = "7";
      {4'd5, 8'b00000111}: ch = "8";
      {4'd5, 8'b00001111}: ch = "9";
      {4'd6, 8'b00101010}: ch = ".";
      {4'd6, 8'b00110011}: ch = ",";
      {4'd6, 8'b00001100}: ch = "?";
      {4'd6, 8'b00000111}: ch = ":";
      {4'd6, 8'b00100001}: ch = "-";
      {4'd6, 8'b00010110}: ch = "@";
      default:             ch = CHAR_NONE;
    endcase
    return ch;
  endfunction

endpackage

@@ rtl/morse_symbol_decoder_top.sv @@
// Channel   Direction  Handshake           Payload
// in        to block   in_valid/in_stall   in_data   (symbol, end_of_message)
// out       from block out_valid/out_stall out_data  (character, char_valid,
//                                                     decode_error, last)
// cfg       to block   cfg_wen             cfg_wdata (separator_char)
//
// Flow: one input transfer per clock while in_stall is low. The transfer
//   loads the input register; the output register, or the skid entry
//   behind it, is then loaded from the single-pass token update and table
//   match.
// Reset: rst is synchronous, active high; it clears the token and sets the
//   separator to a space.
// Stalls: a two-entry result buffer (output register plus skid) parts the
//   sides; in_stall rises only when both entries are full and an item waits.
`include "morse_symbol_decoder_top_macros.svh"

module morse_symbol_decoder_top
  import msd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  sym_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output sym_out_t out_data,
  input  logic     cfg_wen,
  input  logic [7:0] cfg_wdata
);

  // Separator register
  logic [7:0] separator_char;

  // Input register
  logic    s1_valid;
  sym_in_t s1_data;

  // Token accumulator
  logic [PATTERN_BITS-1:0] code_pattern, code_pattern_next;
  logic [LEN_W-1:0]        code_length, code_length_next;
  logic                    slash_seen, slash_seen_next;
  logic                    token_invalid, token_invalid_next;

  // Skid entry behind the output register
  logic     skid_valid;
  sym_out_t skid_data;

  // Token after the current symbol is folded in (non-separator path)
  logic [PATTERN_BITS-1:0] upd_pattern;
  logic [LEN_W-1:0]        upd_length;
  logic                    upd_slash;
  logic                    upd_invalid;

  // Token being closed and its decode
  logic [PATTERN_BITS-1:0] cls_pattern;
  logic [LEN_W-1:0]        cls_length;
  logic                    cls_slash;
  logic                    cls_invalid;
  logic [7:0]              lookup_char;
  logic                    cls_error;

  logic     is_sep;
  logic     closing;
  logic     fire;
  logic     push;
  logic     pop;
  sym_out_t result;

  // Process the held item only while the skid entry is free; a result can
  // then always land in the output register or the skid.
  assign fire     = s1_valid && !skid_valid;
  assign in_stall = s1_valid && skid_valid;
  assign pop      = out_valid && !out_stall;

  assign is_sep = (s1_data.symbol == separator_char);

  // Fold a non-separator symbol into the token.
  always_comb begin
    upd_pattern = code_pattern;
    upd_length  = code_length;
    upd_slash   = slash_seen;
    upd_invalid = token_invalid;
    if (s1_data.symbol == CHAR_DOT || s1_data.symbol == CHAR_DASH) begin
      if (slash_seen) begin
        upd_invalid = 1'b1;
      end
      if (code_length >= MAX_CODE_LENGTH) begin
        // drop the overlong element, remember the token is bad
        upd_invalid = 1'b1;
      end else begin
        if (code_length < LEN_W'(PATTERN_BITS) && s1_data.symbol == CHAR_DASH) begin
          upd_pattern[code_length[$clog2(PATTERN_BITS)-1:0]] = 1'b1;
        end
        upd_length = code_length + 4'd1;
      end
    end else if (s1_data.symbol == CHAR_SLASH) begin
      if (code_length != '0 || slash_seen) begin
        upd_invalid = 1'b1;
      end
      upd_slash = 1'b1;
    end else begin
      upd_invalid = 1'b1;
    end
  end

  // A separator closes the token as it stands; end of message closes the
  // token after the symbol is taken in. Separator match wins over '.', '-', '/'.
  always_comb begin
    if (is_sep) begin
      cls_pattern = code_pattern;
      cls_length  = code_length;
      cls_slash   = slash_seen;
      cls_invalid = token_invalid;
    end else begin
      cls_pattern = upd_pattern;
      cls_length  = upd_length;
      cls_slash   = upd_slash;
      cls_invalid = upd_invalid;
    end
  end

  assign closing = is_sep || s1_data.end_of_message;

  assign lookup_char = morse_lookup(cls_length, cls_pattern);
  assign cls_error   = cls_invalid ||
                       (!cls_slash && (cls_length > LEN_W'(PATTERN_BITS) ||
                                       lookup_char == CHAR_NONE));

  always_comb begin
    result.character    = cls_error ? CHAR_NONE : (cls_slash ? CHAR_SPACE : lookup_char);
    result.char_valid   = !cls_error;
    result.decode_error = cls_error;
    result.last         = s1_data.end_of_message;
  end

  // An empty token closes silently.
  assign push = fire && closing &&
                (cls_length != '0 || cls_slash || cls_invalid);

  // Hold the token, advance it, or clear it on close.
  always_comb begin
    code_pattern_next  = code_pattern;
    code_length_next   = code_length;
    slash_seen_next    = slash_seen;
    token_invalid_next = token_invalid;
    if (fire) begin
      if (closing) begin
        code_pattern_next  = '0;
        code_length_next   = '0;
        slash_seen_next    = 1'b0;
        token_invalid_next = 1'b0;
      end else begin
        code_pattern_next  = upd_pattern;
        code_length_next   = upd_length;
        slash_seen_next    = upd_slash;
        token_invalid_next = upd_invalid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      separator_char <= SEPARATOR_RESET;
      s1_valid       <= 1'b0;
      code_pattern   <= '0;
      code_length    <= '0;
      slash_seen     <= 1'b0;
      token_invalid  <= 1'b0;
      out_valid      <= 1'b0;
      skid_valid     <= 1'b0;
    end else begin
      if (cfg_wen) begin
        separator_char <= cfg_wdata;
      end

      // Input register: take a transfer whenever it is empty or draining.
      if (!in_stall) begin
        s1_valid <= in_valid;
      end

      code_pattern  <= code_pattern_next;
      code_length   <= code_length_next;
      slash_seen    <= slash_seen_next;
      token_invalid <= token_invalid_next;

      // Result buffer: refill from skid first, else load a new result into
      // whichever entry is free.
      if (skid_valid) begin
        if (pop) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end
      end else if (push) begin
        if (!out_valid || pop) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_data <= in_data;
    end
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_data <= result;
      end else begin
        skid_data <= result;
      end
    end
  end

  // The skid entry fills only behind a held output register.
  `MSD_ASSERT_IMPL(a_skid_behind_out, skid_valid, out_valid, "skid full with output empty")

  // Length saturates at the maximum code length.
  `MSD_ASSERT_IMPL(a_len_bound, 1'b1, code_length <= MAX_CODE_LENGTH,
                   "code length past maximum")

  // A slash never shares a valid token with elements.
  `MSD_ASSERT_IMPL(a_slash_alone, slash_seen, code_length == '0 || token_invalid,
                   "slash mixed with elements in a valid token")

  // A closing item always leaves an empty token behind.
  `MSD_ASSERT_NEXT(a_close_clears, fire && closing,
                   code_length == '0 && !slash_seen && !token_invalid,
                   "token not cleared after close")

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import msd_pkg::*;

  localparam int BOOK_SIZE       = 42;
  localparam int SETTLE_CYCLES   = 4;    // pipeline depth plus skid, rounded up
  localparam int ITEMS_PER_PHASE = 310;
  localparam int MAX_IDLE        = 19;

  logic       clk;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  sym_in_t    in_data   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  sym_out_t   out_data;
  logic       cfg_wen   = 1'b0;
  logic [7:0] cfg_wdata = '0;

  morse_symbol_decoder_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  // Code book: element strings and the characters they stand for.
  string code_book [BOOK_SIZE] = '{
    ".-",     "-...",   "-.-.",   "-..",    ".",      "..-.",   "--.",
    "....",   "..",     ".---",   "-.-",    ".-..",   "--",     "-.",
    "---",    ".--.",   "--.-",   ".-.",    "...",    "-",      "..-",
    "...-",   ".--",    "-..-",   "-.--",   "--..",
    "-----",  ".----",  "..---",  "...--",  "....-",  ".....",  "-....",
    "--...",  "---..",  "----.",
    ".-.-.-", "--..--", "..--..", "---...", "-....-", ".--.-."
  };
  logic [7:0] code_letter [BOOK_SIZE] = '{
    "A", "B", "C", "D", "E", "F", "G", "H", "I", "J", "K", "L", "M",
    "N", "O", "P", "Q", "R", "S", "T", "U", "V", "W", "X", "Y", "Z",
    "0", "1", "2", "3", "4", "5", "6", "7", "8", "9",
    ".", ",", "?", ":", "-", "@"
  };

  // Predicted decoder state, kept at the block's widths.
  logic [7:0]       sep_char;
  logic [7:0]       tok_pattern;
  logic [LEN_W-1:0] tok_len;
  logic             tok_slash;
  logic             tok_bad;

  sym_out_t expected_chars [$];
  bit       gaps_on = 1'b1;
  int       items_sent;
  int       mismatch_count;

  // 20 ns clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Abort a hung run.
  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Decoder prediction
  // ---------------------------------------------------------------------

  function automatic void clear_token();
    tok_pattern = '0;
    tok_len     = '0;
    tok_slash   = 1'b0;
    tok_bad     = 1'b0;
  endfunction

  // Search the code book for the gathered token; CHAR_NONE when absent.
  function automatic logic [7:0] match_token();
    string            code;
    logic [LEN_W-1:0] len;
    logic [7:0]       pat;
    for (int i = 0; i < BOOK_SIZE; i++) begin
      code = code_book[i];
      len  = LEN_W'(code.len());
      pat  = '0;
      for (int j = 0; j < code.len(); j++)
        if (code.getc(j) == CHAR_DASH) pat[j] = 1'b1;
      if (len == tok_len && pat == tok_pattern) return code_letter[i];
    end
    return CHAR_NONE;
  endfunction

  // Close the token; return 1 with a result unless the token is empty.
  function automatic bit close_token(input logic last, output sym_out_t res);
    logic [7:0] ch;
    logic       err;
    res = '0;
    if (tok_len == 0 && !tok_slash && !tok_bad) return 1'b0;
    ch = CHAR_NONE;
    if (tok_bad) begin
      err = 1'b1;
    end else if (tok_slash) begin
      ch  = CHAR_SPACE;
      err = 1'b0;
    end else if (tok_len > PATTERN_BITS) begin
      err = 1'b1;
    end else begin
      ch  = match_token();
      err = (ch == CHAR_NONE);
    end
    res.character    = err ? CHAR_NONE : ch;
    res.char_valid   = !err;
    res.decode_error = err;
    res.last         = last;
    clear_token();
    return 1'b1;
  endfunction

  // Advance the predicted state by one symbol; return 1 when it yields a result.
  function automatic bit decode_symbol(input sym_in_t item, output sym_out_t res);
    res = '0;
    // The separator match wins over every other meaning of the byte.
    if (item.symbol == sep_char) return close_token(item.end_of_message, res);
    if (item.symbol == CHAR_DOT || item.symbol == CHAR_DASH) begin
      if (tok_slash) tok_bad = 1'b1;
      if (tok_len >= MAX_CODE_LENGTH) begin
        // Drop the extra element and mark the token spoiled.
        tok_bad = 1'b1;
      end else begin
        if (tok_len < PATTERN_BITS && item.symbol == CHAR_DASH)
          tok_pattern[tok_len[2:0]] = 1'b1;
        tok_len = tok_len + 1'b1;
      end
    end else if (item.symbol == CHAR_SLASH) begin
      if (tok_len != 0 || tok_slash) tok_bad = 1'b1;
      tok_slash = 1'b1;
    end else begin
      tok_bad = 1'b1;
    end
    if (item.end_of_message) return close_token(1'b1, res);
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------

  // Offer one symbol and hold it until the transfer. Valid stays high after
  // the transfer so back-to-back symbols need no second assignment per step.
  task automatic send_symbol(input logic [7:0] sym, input logic eom);
    int       gap;
    sym_in_t  item;
    sym_out_t res;
    gap                 = gaps_on ? $urandom_range(0, MAX_IDLE) : 0;
    item.symbol         = sym;
    item.end_of_message = eom;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    if (decode_symbol(item, res)) expected_chars.insert(expected_chars.size(), res);
    items_sent++;
  endtask

  // Drop valid, wait until every predicted result has drained, then let the
  // pipeline settle for symbols that produce no result.
  task automatic wait_for_results(input int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Change the separator only with the block idle.
  task automatic write_separator(input logic [7:0] value);
    wait_for_results(SETTLE_CYCLES);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    sep_char   = value;
  endtask

  // Result sink: draw a stall length per transfer, then take one result.
  initial begin : result_sink
    int hold;
    while (rst) @(posedge clk);
    forever begin
      hold = gaps_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Scoreboard: compare each output transfer with the oldest prediction.
  always @(posedge clk) begin : check_result
    sym_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected result: character %h char_valid %b decode_error %b last %b",
               out_data.character, out_data.char_valid, out_data.decode_error,
               out_data.last);
        mismatch_count++;
      end else begin
        want = expected_chars.pop_front();
        if (out_data.character !== want.character) begin
          $error("character: expected %h, got %h", want.character, out_data.character);
          mismatch_count++;
        end
        if (out_data.char_valid !== want.char_valid) begin
          $error("char_valid: expected %b, got %b", want.char_valid, out_data.char_valid);
          mismatch_count++;
        end
        if (out_data.decode_error !== want.decode_error) begin
          $error("decode_error: expected %b, got %b",
                 want.decode_error, out_data.decode_error);
          mismatch_count++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %b, got %b", want.last, out_data.last);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // T closed by the reset separator, E closed by end of message.
  task automatic test_letters();
    send_symbol(CHAR_DASH, 1'b0);
    send_symbol(sep_char, 1'b0);
    send_symbol(CHAR_DOT, 1'b1);
  endtask

  // Eight dots is an error pattern; nine dashes overflow the token.
  task automatic test_error_patterns();
    for (int i = 0; i < 8; i++) send_symbol(CHAR_DOT, i == 7);
    for (int i = 0; i < 9; i++) send_symbol(CHAR_DASH, i == 8);
  endtask

  // Lone slash gives a space; slash mixed with elements in either order fails.
  task automatic test_slash_tokens();
    send_symbol(CHAR_SLASH, 1'b0);
    send_symbol(sep_char, 1'b0);
    send_symbol(CHAR_DOT, 1'b0);
    send_symbol(CHAR_SLASH, 1'b0);
    send_symbol(sep_char, 1'b0);
    send_symbol(CHAR_SLASH, 1'b0);
    send_symbol(CHAR_DOT, 1'b1);
  endtask

  // A stray byte spoils the token; an empty token closes with no result.
  task automatic test_other_bytes();
    send_symbol(8'hFF, 1'b1);
    send_symbol(sep_char, 1'b1);
  endtask

  // With '.' as separator the dot only closes the token.
  task automatic test_separator_priority();
    write_separator(CHAR_DOT);
    send_symbol(CHAR_DASH, 1'b0);
    send_symbol(CHAR_DOT, 1'b1);
  endtask

  // One message of well-formed codes mixed with slashes, broken tokens and noise.
  task automatic send_message(input int n_tokens);
    logic [7:0] tok [$];
    string      code;
    int         kind;
    int         r;
    bit         last_tok;
    bit         eom_inside;
    for (int t = 0; t < n_tokens; t++) begin
      last_tok = (t == n_tokens - 1);
      tok.delete();
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        code = code_book[$urandom_range(0, BOOK_SIZE - 1)];
        for (int j = 0; j < code.len(); j++) tok.insert(tok.size(), code.getc(j));
        // Corrupt an occasional good token with a random byte.
        if ($urandom_range(0, 19) == 0)
          tok.insert($urandom_range(0, tok.size()), 8'($urandom_range(0, 255)));
      end else if (kind < 78) begin
        tok.insert(tok.size(), CHAR_SLASH);
      end else begin
        repeat ($urandom_range(0, 11)) begin
          r = $urandom_range(0, 9);
          if (r < 4)       tok.insert(tok.size(), CHAR_DOT);
          else if (r < 8)  tok.insert(tok.size(), CHAR_DASH);
          else if (r == 8) tok.insert(tok.size(), CHAR_SLASH);
          else             tok.insert(tok.size(), 8'($urandom_range(0, 255)));
        end
      end
      // End the message either on its last element or on a trailing separator.
      eom_inside = last_tok && tok.size() != 0 && $urandom_range(0, 1) == 1;
      foreach (tok[i]) send_symbol(tok[i], eom_inside && i == tok.size() - 1);
      if (!eom_inside) begin
        if ($urandom_range(0, 9) == 0) send_symbol(sep_char, 1'b0);
        send_symbol(sep_char, last_tok);
      end
    end
  endtask

  // Random traffic under a series of separators, extremes included.
  task automatic test_random_traffic();
    logic [7:0] phase_sep [6];
    int         phase_end;
    phase_sep    = '{SEPARATOR_RESET, 8'h00, 8'hFF, 8'h00, CHAR_SLASH, CHAR_DASH};
    phase_sep[3] = 8'($urandom_range(0, 255));
    foreach (phase_sep[p]) begin
      write_separator(phase_sep[p]);
      phase_end = items_sent + ITEMS_PER_PHASE;
      while (items_sent < phase_end) begin
        // Mostly idle gaps on both sides, with full-rate stretches mixed in.
        gaps_on = ($urandom_range(0, 4) != 0);
        send_message($urandom_range(1, 6));
        // Hold off now and then until the output side is fully drained.
        if ($urandom_range(0, 15) == 0) wait_for_results(0);
      end
    end
    gaps_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------

  initial begin
    sep_char = SEPARATOR_RESET;
    clear_token();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_letters();
    test_error_patterns();
    test_slash_tokens();
    test_other_bytes();
    test_separator_priority();
    test_random_traffic();

    // Drain, then keep watching for stray results.
    wait_for_results(SETTLE_CYCLES * 4);
    if (mismatch_count == 0 && expected_chars.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/msd_pkg.sv
rtl/morse_symbol_decoder_top.sv
verif/tb.sv
